// ===== rtl/aes_round_transform_core_assert.svh =====
// Assertion macros for the AES round transform core.
// Included by modules that check their own control logic.
`ifndef AES_ROUND_TRANSFORM_CORE_ASSERT_SVH
`define AES_ROUND_TRANSFORM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ART_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ART_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ART_ASSERT(label, clk, rst_n, prop, msg)
`define ART_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/art_pkg.sv =====
// Shared types, commands and GF(2^8) / S-box functions for the AES round transform.
// No dependencies.
package art_pkg;
	localparam int NumLanes = 4;
	localparam logic [8:0] GfPoly = 9'h11B;

	typedef enum logic [1:0] {
		CMD_SUB = 2'd0,
		CMD_SHIFT = 2'd1,
		CMD_MIX = 2'd2,
		CMD_ARK = 2'd3
	} cmd_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [3:0] col_t;

	typedef struct packed {
		cmd_t cmd;
		logic inv;
	} lane_ctl_t;

	// multiply by x, reduce by the field polynomial
	function automatic byte_t xtime(input byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly[7:0] : 8'h00);
	endfunction

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = xtime(x);
		end
		gf_mul = acc;
	endfunction

	function automatic byte_t gf_inv(input byte_t a);
		byte_t r;
		byte_t p;
		r = 8'h01;
		p = a;
		// exponent 254: bits 1..7 set
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gf_mul(r, p);
			p = gf_mul(p, p);
		end
		gf_inv = r;
	endfunction

	function automatic byte_t rotl(input byte_t v, input int n);
		rotl = byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	// constant tables built at elaboration
	function automatic byte_t sbox_fwd_f(input byte_t v);
		byte_t b;
		b = gf_inv(v);
		sbox_fwd_f = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
	endfunction

	function automatic byte_t sbox_inv_f(input byte_t v);
		sbox_inv_f = gf_inv(rotl(v, 1) ^ rotl(v, 3) ^ rotl(v, 6) ^ 8'h05);
	endfunction

	typedef byte_t [255:0] sbox_t;

	function automatic sbox_t build_sbox(input logic inv);
		sbox_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv ? sbox_inv_f(byte_t'(i)) : sbox_fwd_f(byte_t'(i));
		end
		build_sbox = t;
	endfunction

	localparam sbox_t SboxFwd = build_sbox(1'b0);
	localparam sbox_t SboxInv = build_sbox(1'b1);
endpackage

// ===== rtl/aes_round_transform_core.sv =====
// Top level of the AES round transform: four column lanes, merge with shift rows,
// one output register. Depends on art_pkg, art_lane and the assertion header.
//
//  channel | signals                                   | handshake
//  in      | cmd state_hi state_lo key_hi key_lo        | in_valid / in_ready
//  out     | result_hi result_lo                        | out_valid / out_ready
//  cfg     | direction_we direction_wd                  | write enable, no wait
//
// Registered result the cycle after accept; one beat per cycle unless out_ready is low.
// in_ready is high while the output register is empty or being taken this cycle.
// arst_n clears valid and direction; a stalled result holds in the output register.
`include "aes_round_transform_core_assert.svh"
module aes_round_transform_core
	import art_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic direction_we,
	input logic direction_wd,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [63:0] state_hi,
	input logic [63:0] state_lo,
	input logic [63:0] key_hi,
	input logic [63:0] key_lo,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);
	logic dir_q;
	lane_ctl_t ctl;
	byte_t [15:0] s, k, t, shf;
	col_t [NumLanes-1:0] lane_out;
	logic [127:0] res_s1;
	logic vld_s1;

	assign ctl.cmd = cmd_t'(cmd);
	assign ctl.inv = dir_q;

	// unpack, byte 0 in the top bits
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			s[i] = state_hi[56 - 8*i +: 8];
			s[i+8] = state_lo[56 - 8*i +: 8];
			k[i] = key_hi[56 - 8*i +: 8];
			k[i+8] = key_lo[56 - 8*i +: 8];
		end
	end

	for (genvar c = 0; c < NumLanes; c++) begin : g_lane
		art_lane u_lane (
			.ctl(ctl),
			.col_in(s[4*c +: 4]),
			.key_in(k[4*c +: 4]),
			.col_out(lane_out[c])
		);
	end

	// merge lanes; for CMD_SHIFT, take the row shift across columns instead
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shf[r + 4*c] = dir_q ? s[r + 4*((c + 4 - r) % 4)] : s[r + 4*((c + r) % 4)];
				t[r + 4*c] = lane_out[c][r];
			end
		end
		if (ctl.cmd == CMD_SHIFT) t = shf;
	end

	assign in_ready = !vld_s1 || out_ready;

	// hold direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (direction_we) begin
			dir_q <= direction_wd;
		end
	end

	// advance the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < 16; i++) res_s1[120 - 8*i +: 8] <= t[i];
		end
	end

	assign out_valid = vld_s1;
	assign result_hi = res_s1[127:64];
	assign result_lo = res_s1[63:0];

	`ART_ASSERT(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(res_s1), "result changed while stalled")
	`ART_ASSERT(a_ready, clk, arst_n, out_valid && !out_ready |-> !in_ready, "beat taken while output full")
	`ART_ASSERT(a_fill, clk, arst_n, in_valid && in_ready |=> out_valid, "accepted beat lost")
endmodule

// ===== rtl/art_lane.sv =====
// One column lane: S-box, MixColumns and key add on four bytes.
// Depends on art_pkg.
module art_lane
	import art_pkg::*;
(
	input lane_ctl_t ctl,
	input col_t col_in,
	input col_t key_in,
	output col_t col_out
);
	col_t sub;
	col_t mix;
	col_t m;

	// per-byte tables
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sub[r] = ctl.inv ? SboxInv[col_in[r]] : SboxFwd[col_in[r]];
		end
	end

	// matrix row coefficients, rotated per output row
	always_comb begin
		if (ctl.inv) begin
			m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
		end else begin
			m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
		end
		for (int r = 0; r < 4; r++) begin
			mix[r] = 8'h00;
			for (int j = 0; j < 4; j++) begin
				mix[r] = mix[r] ^ gf_mul(m[(j + 4 - r) % 4], col_in[j]);
			end
		end
	end

	// pick the lane result; shift rows is done in the merge
	always_comb begin
		case (ctl.cmd)
			CMD_SUB: col_out = sub;
			CMD_MIX: col_out = mix;
			CMD_ARK: col_out = col_in ^ key_in;
			default: col_out = col_in;
		endcase
	end
endmodule
